@@ rtl/iebus_frame_receiver_top_defines.svh @@
// assertion macros for the bus frame receiver checker
`ifndef IEBUS_FRAME_RECEIVER_TOP_DEFINES_SVH
`define IEBUS_FRAME_RECEIVER_TOP_DEFINES_SVH

// implication checked on every edge outside reset
`define IFR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// a stalled request keeps valid and its payload
`define IFR_ASSERT_HOLD(lbl, clk, rst_n, vld, rdy, sig, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) \
    (vld && !rdy) |=> (vld && $stable(sig))) else $error(msg);

`endif

@@ rtl/ifr_pkg.sv @@
// shared types and constants of the bus frame receiver
package ifr_pkg;

  localparam int PulseWidthBits = 8;
  localparam int LimitBits      = 8;
  localparam int CmpW = (PulseWidthBits > LimitBits) ? PulseWidthBits : LimitBits;
  localparam int AddrBits   = 12;
  localparam int FieldBits  = 12;
  localparam int ByteBits   = 8;
  localparam int ApbAddrW   = 4;
  localparam int ApbDataW   = 32;

  localparam logic [3:0] MasterBits = 4'd12;
  localparam logic [3:0] SlaveBits  = 4'd12;
  localparam logic [3:0] CtrlBits   = 4'd4;
  localparam logic [3:0] SizeBits   = 4'd8;
  localparam logic [3:0] DataBits   = 4'd8;

  localparam logic [LimitBits-1:0] LimitReset = LimitBits'(26);

  // register index, taken from paddr[3:2]
  localparam logic [1:0] RegLimit     = 2'd0;
  localparam logic [1:0] RegEmulating = 2'd1;
  localparam logic [1:0] RegEmuMaster = 2'd2;

  typedef enum logic [2:0] {
    EvBit    = 3'd0,
    EvMaster = 3'd1,
    EvSlave  = 3'd2,
    EvCtrl   = 3'd3,
    EvSize   = 3'd4,
    EvData   = 3'd5,
    EvDone   = 3'd6,
    EvParity = 3'd7
  } ev_e;

  typedef enum logic [2:0] {
    StgNone   = 3'd0,
    StgMaster = 3'd1,
    StgSlave  = 3'd2,
    StgCtrl   = 3'd3,
    StgSize   = 3'd4,
    StgData   = 3'd5
  } stage_e;

  typedef struct packed {
    logic [LimitBits-1:0] one_bit_limit;
    logic                 emulating;
    logic [AddrBits-1:0]  emulated_master;
  } cfg_t;

  typedef struct packed {
    ev_e                  event_res;
    logic [FieldBits-1:0] field_value;
    logic                 broadcast_bit;
    stage_e               error_stage;
    logic                 drive_ack;
    logic [ByteBits-1:0]  byte_number;
  } res_t;

endpackage

@@ rtl/ifr_if.sv @@
// request and result channel interfaces of the bus frame receiver
interface ifr_req_if;
  logic                               valid;
  logic                               ready;
  logic [ifr_pkg::PulseWidthBits-1:0] pulse_length;

  modport source (output valid, output pulse_length, input ready);
  modport sink (input valid, input pulse_length, output ready);
endinterface

interface ifr_res_if;
  logic                          valid;
  logic                          ready;
  ifr_pkg::ev_e                  event_res;
  logic [ifr_pkg::FieldBits-1:0] field_value;
  logic                          broadcast_bit;
  ifr_pkg::stage_e               error_stage;
  logic                          drive_ack;
  logic [ifr_pkg::ByteBits-1:0]  byte_number;

  modport source (output valid, output event_res, output field_value, output broadcast_bit,
                  output error_stage, output drive_ack, output byte_number, input ready);
  modport sink (input valid, input event_res, input field_value, input broadcast_bit,
                input error_stage, input drive_ack, input byte_number, output ready);
endinterface

@@ rtl/ifr_apb_regs.sv @@
// apb configuration registers of the bus frame receiver
module ifr_apb_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ifr_pkg::ApbAddrW-1:0]  paddr,
  input  logic [ifr_pkg::ApbDataW-1:0]  pwdata,
  output logic [ifr_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready,
  output ifr_pkg::cfg_t                 cfg_o
);

  ifr_pkg::cfg_t cfg_q;
  logic          wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.one_bit_limit   <= ifr_pkg::LimitReset;
      cfg_q.emulating       <= 1'b0;
      cfg_q.emulated_master <= '0;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        ifr_pkg::RegLimit:     cfg_q.one_bit_limit <= pwdata[ifr_pkg::LimitBits-1:0];
        ifr_pkg::RegEmulating: cfg_q.emulating <= pwdata[0];
        ifr_pkg::RegEmuMaster: cfg_q.emulated_master <= pwdata[ifr_pkg::AddrBits-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      ifr_pkg::RegLimit:     prdata = ifr_pkg::ApbDataW'(cfg_q.one_bit_limit);
      ifr_pkg::RegEmulating: prdata = ifr_pkg::ApbDataW'(cfg_q.emulating);
      ifr_pkg::RegEmuMaster: prdata = ifr_pkg::ApbDataW'(cfg_q.emulated_master);
      default:               prdata = '0;
    endcase
  end

endmodule

@@ rtl/ifr_frame_core.sv @@
// input register, frame walker and result register of the bus frame receiver
module ifr_frame_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ifr_pkg::cfg_t cfg_i,
  ifr_req_if.sink       req_i,
  ifr_res_if.source     res_o
);

  localparam logic [3:0] PhStart  = 4'd0;
  localparam logic [3:0] PhBcast  = 4'd1;
  localparam logic [3:0] PhMaster = 4'd2;
  localparam logic [3:0] PhMpar   = 4'd3;
  localparam logic [3:0] PhSlave  = 4'd4;
  localparam logic [3:0] PhSpar   = 4'd5;
  localparam logic [3:0] PhHack   = 4'd6;
  localparam logic [3:0] PhCtrl   = 4'd7;
  localparam logic [3:0] PhCpar   = 4'd8;
  localparam logic [3:0] PhCack   = 4'd9;
  localparam logic [3:0] PhSize   = 4'd10;
  localparam logic [3:0] PhZpar   = 4'd11;
  localparam logic [3:0] PhZack   = 4'd12;
  localparam logic [3:0] PhData   = 4'd13;
  localparam logic [3:0] PhDpar   = 4'd14;
  localparam logic [3:0] PhDack   = 4'd15;

  logic                               in_vld_q;
  logic [ifr_pkg::PulseWidthBits-1:0] pulse_q;
  logic                               out_vld_q;
  ifr_pkg::res_t                      res_q, res_d;
  logic                               step;

  logic [3:0]                     phase_q, phase_d;
  logic [3:0]                     cnt_q, cnt_d;
  logic [ifr_pkg::FieldBits-1:0]  shift_q, shift_d;
  logic                           par_q, par_d;
  logic [ifr_pkg::AddrBits-1:0]   sender_q, sender_d;
  logic                           bcast_q, bcast_d;
  logic [ifr_pkg::ByteBits-1:0]   left_q, left_d;
  logic [ifr_pkg::ByteBits-1:0]   idx_q, idx_d;

  logic                           bit_one;
  logic                           ack_drv;
  logic                           take;
  logic                           clear;
  logic                           end_check;
  logic [3:0]                     fw;
  logic [3:0]                     take_next;
  logic [3:0]                     pass_next;
  logic [3:0]                     cnt_nx;
  logic [ifr_pkg::ByteBits-1:0]   left_nx;
  ifr_pkg::stage_e                code;

  // pipeline handshake
  assign step        = in_vld_q & (~out_vld_q | res_o.ready);
  assign req_i.ready = ~in_vld_q | step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (req_i.valid && req_i.ready) begin
        in_vld_q <= 1'b1;
      end else if (step) begin
        in_vld_q <= 1'b0;
      end
      if (step) begin
        out_vld_q <= 1'b1;
      end else if (res_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      pulse_q <= req_i.pulse_length;
    end
    if (step) begin
      res_q <= res_d;
    end
  end

  // frame state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhStart;
      cnt_q    <= '0;
      shift_q  <= '0;
      par_q    <= 1'b0;
      sender_q <= '0;
      bcast_q  <= 1'b0;
      left_q   <= '0;
      idx_q    <= '0;
    end else if (step) begin
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      shift_q  <= shift_d;
      par_q    <= par_d;
      sender_q <= sender_d;
      bcast_q  <= bcast_d;
      left_q   <= left_d;
      idx_q    <= idx_d;
    end
  end

  always_comb begin
    bit_one   = ifr_pkg::CmpW'(pulse_q) < ifr_pkg::CmpW'(cfg_i.one_bit_limit);
    ack_drv   = ~(cfg_i.emulating && (cfg_i.emulated_master == sender_q));
    cnt_nx    = cnt_q + 4'd1;
    left_nx   = left_q - ifr_pkg::ByteBits'(1);

    phase_d   = phase_q;
    cnt_d     = cnt_q;
    shift_d   = shift_q;
    par_d     = par_q;
    sender_d  = sender_q;
    bcast_d   = bcast_q;
    left_d    = left_q;
    idx_d     = idx_q;

    take      = 1'b0;
    clear     = 1'b0;
    end_check = 1'b0;
    fw        = ifr_pkg::MasterBits;
    take_next = PhStart;
    pass_next = PhStart;
    code      = ifr_pkg::StgNone;

    res_d.event_res     = ifr_pkg::EvBit;
    res_d.field_value   = '0;
    res_d.error_stage   = ifr_pkg::StgNone;
    res_d.drive_ack     = 1'b0;
    res_d.byte_number   = '0;

    unique case (phase_q)
      PhStart: begin
        bcast_d = 1'b0;
        clear   = 1'b1;
        phase_d = PhBcast;
      end
      PhBcast: begin
        bcast_d = bit_one;
        clear   = 1'b1;
        phase_d = PhMaster;
      end
      PhMaster: begin
        take = 1'b1; fw = ifr_pkg::MasterBits; take_next = PhMpar;
      end
      PhSlave: begin
        take = 1'b1; fw = ifr_pkg::SlaveBits; take_next = PhSpar;
      end
      PhCtrl: begin
        take = 1'b1; fw = ifr_pkg::CtrlBits; take_next = PhCpar;
      end
      PhSize: begin
        take = 1'b1; fw = ifr_pkg::SizeBits; take_next = PhZpar;
      end
      PhData: begin
        take = 1'b1; fw = ifr_pkg::DataBits; take_next = PhDpar;
      end
      PhMpar: begin
        code = ifr_pkg::StgMaster; pass_next = PhSlave;
      end
      PhSpar: begin
        code = ifr_pkg::StgSlave; pass_next = PhHack;
      end
      PhCpar: begin
        code = ifr_pkg::StgCtrl; pass_next = PhCack;
      end
      PhZpar: begin
        code = ifr_pkg::StgSize; pass_next = PhZack;
      end
      PhDpar: begin
        code = ifr_pkg::StgData; pass_next = PhDack;
      end
      PhHack: begin
        res_d.drive_ack = ack_drv;
        clear   = 1'b1;
        phase_d = PhCtrl;
      end
      PhCack: begin
        res_d.drive_ack = ack_drv;
        clear   = 1'b1;
        phase_d = PhSize;
      end
      PhZack: begin
        res_d.drive_ack = ack_drv;
        clear     = 1'b1;
        end_check = 1'b1;
      end
      PhDack: begin
        res_d.drive_ack = ack_drv;
        clear     = 1'b1;
        idx_d     = idx_q + ifr_pkg::ByteBits'(1);
        left_d    = left_nx;
        end_check = 1'b1;
      end
    endcase

    if (take) begin
      shift_d = {shift_q[ifr_pkg::FieldBits-2:0], bit_one};
      par_d   = par_q ^ bit_one;
      if (cnt_nx >= fw) begin
        cnt_d   = '0;
        phase_d = take_next;
      end else begin
        cnt_d   = cnt_nx;
      end
    end

    // frame ends on the ack after the last byte or after a zero size
    if (end_check) begin
      if (left_d == '0) begin
        res_d.event_res = ifr_pkg::EvDone;
        phase_d         = PhStart;
      end else begin
        phase_d         = PhData;
      end
    end

    if (code != ifr_pkg::StgNone) begin
      clear = 1'b1;
      if (bit_one != par_q) begin
        res_d.event_res   = ifr_pkg::EvParity;
        res_d.error_stage = code;
        phase_d           = PhStart;
      end else begin
        res_d.event_res   = ifr_pkg::ev_e'(code);
        res_d.field_value = shift_q;
        phase_d           = pass_next;
        if (code == ifr_pkg::StgMaster) begin
          sender_d = shift_q;
        end
        if (code == ifr_pkg::StgSize) begin
          left_d = shift_q[ifr_pkg::ByteBits-1:0];
          idx_d  = '0;
        end
        if (code == ifr_pkg::StgData) begin
          res_d.byte_number = idx_q;
        end
      end
    end

    if (clear) begin
      cnt_d   = '0;
      shift_d = '0;
      par_d   = 1'b0;
    end

    res_d.broadcast_bit = bcast_d;
  end

  assign res_o.valid         = out_vld_q;
  assign res_o.event_res     = res_q.event_res;
  assign res_o.field_value   = res_q.field_value;
  assign res_o.broadcast_bit = res_q.broadcast_bit;
  assign res_o.error_stage   = res_q.error_stage;
  assign res_o.drive_ack     = res_q.drive_ack;
  assign res_o.byte_number   = res_q.byte_number;

endmodule

@@ rtl/iebus_frame_receiver_top.sv @@
// top level of the bus frame receiver
// The receiver takes one measured bit pulse per request and returns exactly one result
// per request, sustaining one request per clock cycle unless the result is held on ready.
// A request is first held in the input register; then the frame walker updates its state
// and loads the result register, which drives the result channel. While the result waits
// on ready, one more request is held in the input register; the frame walker's state update
// per request sets the rate. Configuration goes through the apb port; the user must write it
// only while no request is in flight, and the block itself does not enforce this.
module iebus_frame_receiver_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ifr_pkg::ApbAddrW-1:0]  paddr,
  input  logic [ifr_pkg::ApbDataW-1:0]  pwdata,
  output logic [ifr_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready,
  ifr_req_if.sink                       req_i,
  ifr_res_if.source                     res_o
);

  ifr_pkg::cfg_t cfg;

  ifr_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ifr_frame_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .req_i  (req_i),
    .res_o  (res_o)
  );

endmodule

@@ rtl/ifr_checker.sv @@
// port-level assertions of the bus frame receiver and their bind
`include "iebus_frame_receiver_top_defines.svh"

module ifr_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          res_valid_i,
  input logic                          res_ready_i,
  input logic [2:0]                    event_res_i,
  input logic [ifr_pkg::FieldBits-1:0] field_value_i,
  input logic [2:0]                    error_stage_i,
  input logic                          drive_ack_i,
  input logic [ifr_pkg::ByteBits-1:0]  byte_number_i
);

  `IFR_ASSERT_HOLD(a_res_hold, clk_i, rst_ni, res_valid_i, res_ready_i, field_value_i, "result changed while stalled")

  `IFR_ASSERT(a_stage_on_err, clk_i, rst_ni, (res_valid_i && (event_res_i == ifr_pkg::EvParity)) |-> (error_stage_i != ifr_pkg::StgNone), "parity error without stage")

  `IFR_ASSERT(a_stage_only_err, clk_i, rst_ni, (res_valid_i && (event_res_i != ifr_pkg::EvParity)) |-> (error_stage_i == ifr_pkg::StgNone), "stage set without parity error")

  `IFR_ASSERT(a_field_quiet, clk_i, rst_ni, (res_valid_i && (drive_ack_i || (byte_number_i != '0))) |-> ((error_stage_i == ifr_pkg::StgNone) && ((event_res_i == ifr_pkg::EvBit) || (event_res_i == ifr_pkg::EvDone) || (event_res_i == ifr_pkg::EvData))), "ack or byte index on wrong event")

endmodule

bind iebus_frame_receiver_top ifr_checker u_ifr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .res_valid_i   (res_o.valid),
  .res_ready_i   (res_o.ready),
  .event_res_i   (res_o.event_res),
  .field_value_i (res_o.field_value),
  .error_stage_i (res_o.error_stage),
  .drive_ack_i   (res_o.drive_ack),
  .byte_number_i (res_o.byte_number)
);

@@ sim/tb_iebus_frame_receiver_top.sv @@
// self-checking testbench of the bus frame receiver with random frames, idling and back-pressure
module tb_iebus_frame_receiver_top;
  import ifr_pkg::*;

  typedef enum logic [3:0] {
    PhStart, PhBcast, PhMaster, PhMpar, PhSlave, PhSpar, PhHack, PhCtrl,
    PhCpar, PhCack, PhSize, PhZpar, PhZack, PhData, PhDpar, PhDack
  } walk_phase_e;

  typedef struct packed {
    walk_phase_e          phase;
    logic [3:0]           cnt;
    logic [FieldBits-1:0] shift;
    logic                 par;
    logic [AddrBits-1:0]  sender;
    logic                 bcast;
    logic [ByteBits-1:0]  left;
    logic [ByteBits-1:0]  idx;
  } walk_t;

  typedef logic [PulseWidthBits-1:0] pulse_t;

  localparam int PulseMax   = (1 << PulseWidthBits) - 1;
  localparam int NumPhases  = 8;
  localparam int PhaseItems = 160;
  localparam int HoldCycles = 60;

  localparam int unsigned LimTab    [NumPhases] = '{26, 26, 0, 255, 1, 128, 26, 200};
  localparam int unsigned EmuTab    [NumPhases] = '{0, 1, 1, 0, 1, 1, 0, 1};
  localparam int unsigned MasterTab [NumPhases] = '{0, 'h5A3, 0, 'hFFF, 'hFFF, 'h800, 0, 'h001};

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  ifr_req_if req ();
  ifr_res_if res ();

  iebus_frame_receiver_top uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .req_i   (req),
    .res_o   (res)
  );

  cfg_t   cfg;
  walk_t  gen_st;
  walk_t  chk_st;
  pulse_t pulse_q [$];
  res_t   expected_q [$];
  int     queued_total;
  int     taken_total;
  int     phase_items;
  int     mismatches;
  int     idle_mode;
  int     hold_left;
  bit     hold_arm;
  bit     hold_used;
  bit     req_taken;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic void clear_field(inout walk_t st);
    st.cnt   = '0;
    st.shift = '0;
    st.par   = 1'b0;
  endfunction

  function automatic logic ack_driven(walk_t st);
    return !(cfg.emulating && cfg.emulated_master == st.sender);
  endfunction

  // one bus bit through the frame walker
  function automatic res_t walk_step(inout walk_t st, input pulse_t pulse);
    res_t        r;
    logic        b;
    stage_e      code;
    walk_phase_e nxt;
    walk_phase_e after;
    logic [3:0]  width;
    r     = '0;
    code  = StgNone;
    nxt   = PhStart;
    after = PhStart;
    width = '0;
    b     = (CmpW'(pulse) < CmpW'(cfg.one_bit_limit));
    case (st.phase)
      PhStart: begin
        st.bcast = 1'b0;
        clear_field(st);
        st.phase = PhBcast;
      end
      PhBcast: begin
        st.bcast = b;
        clear_field(st);
        st.phase = PhMaster;
      end
      PhMaster: begin width = MasterBits; after = PhMpar; end
      PhSlave:  begin width = SlaveBits;  after = PhSpar; end
      PhCtrl:   begin width = CtrlBits;   after = PhCpar; end
      PhSize:   begin width = SizeBits;   after = PhZpar; end
      PhData:   begin width = DataBits;   after = PhDpar; end
      PhMpar:   begin code = StgMaster; nxt = PhSlave; end
      PhSpar:   begin code = StgSlave;  nxt = PhHack;  end
      PhCpar:   begin code = StgCtrl;   nxt = PhCack;  end
      PhZpar:   begin code = StgSize;   nxt = PhZack;  end
      PhDpar:   begin code = StgData;   nxt = PhDack;  end
      PhHack, PhCack: begin
        r.drive_ack = ack_driven(st);
        clear_field(st);
        st.phase = (st.phase == PhHack) ? PhCtrl : PhSize;
      end
      default: begin
        // size ack or data ack, either may close the frame
        r.drive_ack = ack_driven(st);
        clear_field(st);
        if (st.phase == PhDack) begin
          st.idx  = st.idx + 1'b1;
          st.left = st.left - 1'b1;
        end
        if (st.left == '0) begin
          r.event_res = EvDone;
          st.phase    = PhStart;
        end else begin
          st.phase = PhData;
        end
      end
    endcase
    if (width != '0) begin
      st.shift = {st.shift[FieldBits-2:0], b};
      st.par   = st.par ^ b;
      st.cnt   = st.cnt + 1'b1;
      if (st.cnt >= width) begin
        st.cnt   = '0;
        st.phase = after;
      end
    end
    if (code != StgNone) begin
      if (b != st.par) begin
        r.event_res   = EvParity;
        r.error_stage = code;
        st.phase      = PhStart;
      end else begin
        r.event_res   = ev_e'(3'(code));
        r.field_value = st.shift;
        if (code == StgMaster) st.sender = st.shift;
        if (code == StgSize) begin
          st.left = st.shift[ByteBits-1:0];
          st.idx  = '0;
        end
        if (code == StgData) r.byte_number = st.idx;
        st.phase = nxt;
      end
      clear_field(st);
    end
    r.broadcast_bit = st.bcast;
    return r;
  endfunction

  function automatic pulse_t rand_pulse();
    return pulse_t'($urandom_range(0, PulseMax));
  endfunction

  // pulse lengths crowd the threshold and the ends of the range
  function automatic pulse_t pulse_for_bit(logic b);
    int unsigned lim;
    int unsigned r;
    lim = cfg.one_bit_limit;
    r   = $urandom_range(0, 99);
    if (b && lim != 0) begin
      if (r < 25) return pulse_t'(lim - 1);
      if (r < 35) return '0;
      return pulse_t'($urandom_range(0, lim - 1));
    end
    if (r < 25) return pulse_t'(lim);
    if (r < 35) return pulse_t'(PulseMax);
    return pulse_t'($urandom_range(lim, PulseMax));
  endfunction

  function automatic void push_pulse(pulse_t p);
    res_t ignored;
    pulse_q.push_back(p);
    ignored = walk_step(gen_st, p);
    queued_total++;
    phase_items++;
  endfunction

  function automatic void push_field(logic [FieldBits-1:0] value, int width, logic spoil);
    logic   par;
    pulse_t p;
    int     i;
    par = 1'b0;
    for (i = width - 1; i >= 0; i--) begin
      p   = pulse_for_bit(value[i]);
      par = par ^ (p < cfg.one_bit_limit);
      push_pulse(p);
    end
    push_pulse(pulse_for_bit(par ^ spoil));
  endfunction

  function automatic void resync();
    while (gen_st.phase != PhStart) push_pulse(rand_pulse());
  endfunction

  function automatic void push_frame();
    int unsigned          spoil_field;
    int unsigned          spoil_byte;
    int unsigned          size;
    int unsigned          r;
    logic [FieldBits-1:0] master;
    spoil_field = ($urandom_range(0, 99) < 20) ? $urandom_range(0, 4) : 5;
    spoil_byte  = $urandom_range(0, 3);
    r           = $urandom_range(0, 99);
    if (r < 45) size = $urandom_range(0, 2);
    else if (r < 95) size = $urandom_range(3, 6);
    else size = $urandom_range(200, 255);
    // long frames are cut short by a bad data byte
    if (size > 150) spoil_field = 4;
    master = ($urandom_range(0, 99) < 30) ? cfg.emulated_master
                                          : FieldBits'($urandom_range(0, 4095));
    push_pulse(rand_pulse());
    push_pulse(pulse_for_bit(1'($urandom_range(0, 1))));
    push_field(master, MasterBits, spoil_field == 0);
    if (gen_st.phase == PhStart) return;
    push_field(FieldBits'($urandom_range(0, 4095)), SlaveBits, spoil_field == 1);
    if (gen_st.phase == PhStart) return;
    push_pulse(rand_pulse());
    push_field(FieldBits'($urandom_range(0, 15)), CtrlBits, spoil_field == 2);
    if (gen_st.phase == PhStart) return;
    push_pulse(rand_pulse());
    push_field(FieldBits'(size), SizeBits, spoil_field == 3);
    if (gen_st.phase == PhStart) return;
    push_pulse(rand_pulse());
    while (gen_st.phase != PhStart) begin
      push_field(FieldBits'($urandom_range(0, 255)), DataBits,
                 spoil_field == 4 && gen_st.idx == spoil_byte);
      if (gen_st.phase != PhStart) push_pulse(rand_pulse());
    end
  endfunction

  function automatic bit roll(int unsigned pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [ApbDataW-1:0] value);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      RegLimit:     cfg.one_bit_limit   = value[LimitBits-1:0];
      RegEmulating: cfg.emulating       = value[0];
      default:      cfg.emulated_master = value[AddrBits-1:0];
    endcase
    @(negedge clk_i);
    pwrite  = 1'b0;
    penable = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== value) begin
      $error("register %0d expected %0h got %0h", idx, value, prdata);
      mismatches++;
    end
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk_i); while (taken_total != queued_total || expected_q.size() != 0);
  endtask

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s expected %0d got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // request driver
  always @(negedge clk_i) begin
    if (rst_ni && (!req.valid || req_taken)) begin
      if (pulse_q.size() != 0 && !roll(idle_mode == 1 ? 64 : idle_mode == 3 ? 7 : 0)) begin
        req.valid        <= 1'b1;
        req.pulse_length <= pulse_q.pop_front();
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= req.valid && req.ready;
      if (req.valid && req.ready) begin
        expected_q.push_back(walk_step(chk_st, req.pulse_length));
        taken_total <= taken_total + 1;
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_arm && !hold_used) begin
      hold_left <= HoldCycles;
      hold_used <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      res.ready <= (hold_left == 0) && !roll(idle_mode == 2 ? 64 : idle_mode == 3 ? 7 : 0);
    end
  end

  // result monitor
  always @(posedge clk_i) begin : result_check
    res_t want;
    if (rst_ni && res.valid && res.ready) begin
      if (expected_q.size() == 0) begin
        $error("result with no request outstanding");
        mismatches++;
      end else begin
        want = expected_q.pop_front();
        check_field("event_res", want.event_res, res.event_res);
        check_field("field_value", want.field_value, res.field_value);
        check_field("broadcast_bit", want.broadcast_bit, res.broadcast_bit);
        check_field("error_stage", want.error_stage, res.error_stage);
        check_field("drive_ack", want.drive_ack, res.drive_ack);
        check_field("byte_number", want.byte_number, res.byte_number);
      end
    end
  end

  initial begin
    int ph;
    int i;
    rst_ni           = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    req.valid        = 1'b0;
    req.pulse_length = '0;
    res.ready        = 1'b0;
    cfg              = '{one_bit_limit: LimitReset, emulating: 1'b0, emulated_master: '0};
    gen_st           = '0;
    chk_st           = '0;
    queued_total     = 0;
    taken_total      = 0;
    mismatches       = 0;
    idle_mode        = 0;
    hold_left        = 0;
    hold_arm         = 1'b0;
    hold_used        = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (ph = 0; ph < NumPhases; ph++) begin
      wait_drained();
      if (ph != 0) begin
        write_reg(RegLimit, ApbDataW'(LimTab[ph]));
        write_reg(RegEmulating, ApbDataW'(EmuTab[ph]));
        write_reg(RegEmuMaster, ApbDataW'(MasterTab[ph]));
      end
      @(posedge clk_i);
      idle_mode   = ph % 4;
      phase_items = 0;
      if (ph == 0) begin
        // start length ignored, all-ones master with a bad parity bit
        push_pulse(pulse_t'(PulseMax));
        push_pulse('0);
        for (i = 0; i < 12; i++) push_pulse(i[0] ? pulse_t'(LimitReset - 1) : '0);
        push_pulse(pulse_t'(LimitReset - 1));
        // broadcast read at the threshold, then a good master
        push_pulse('0);
        push_pulse(pulse_t'(LimitReset));
        push_field(12'hA5C, MasterBits, 1'b0);
      end
      while (phase_items < PhaseItems) begin
        resync();
        if (roll(8)) begin
          repeat ($urandom_range(1, 12)) push_pulse(rand_pulse());
          resync();
        end else begin
          push_frame();
        end
      end
      resync();
      if (ph == 4) hold_arm = 1'b1;
    end

    wait_drained();
    repeat (8) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/ifr_pkg.sv
rtl/ifr_if.sv
rtl/ifr_apb_regs.sv
rtl/ifr_frame_core.sv
rtl/iebus_frame_receiver_top.sv
rtl/ifr_checker.sv
sim/tb_iebus_frame_receiver_top.sv
